FILE: rtl/core/rsie_pkg.sv
// Shared types and constants for the RISC subset instruction executor.
// Holds the transaction payloads, the write-port structs, opcode and funct
// codes and the trap codes. Depends on nothing.
package rsie_pkg;

   localparam int          DATA_WORDS = 4096;
   localparam int          DMEM_AW    = $clog2(DATA_WORDS);
   localparam logic [31:0] START_PC   = 32'h0000_1000;
   localparam logic [31:0] STACK_TOP  = 32'd16380;
   localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;

   // architectural register numbers with a fixed role
   localparam logic [4:0] REG_V0 = 5'd2;
   localparam logic [4:0] REG_A0 = 5'd4;
   localparam logic [4:0] REG_SP = 5'd29;
   localparam logic [4:0] REG_RA = 5'd31;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_ORI     = 6'h0d;
   localparam logic [5:0] OP_XORI    = 6'h0e;
   localparam logic [5:0] OP_LUI     = 6'h0f;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SW      = 6'h2b;

   // funct codes under OP_SPECIAL
   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0c;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_SLT     = 6'h2a;

   typedef enum logic [1:0] {
      TRAP_NONE     = 2'd0,
      TRAP_SYSCALL  = 2'd1,
      TRAP_OVERFLOW = 2'd2,
      TRAP_ILLEGAL  = 2'd3
   } trap_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] instr_word;
      logic [11:0] preload_addr;
      logic [31:0] preload_data;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] next_pc;
      trap_type    trap;
      logic [31:0] syscall_code;
      logic [31:0] syscall_arg;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
   } rsp_payload_type;

   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_write_type;

   typedef struct packed {
      logic               en;
      logic [DMEM_AW-1:0] addr;
      logic [3:0]         be;
      logic [31:0]        data;
   } dmem_write_type;

endpackage

FILE: rtl/core/rsie_regfile.sv
// Register file: 32 x 32 bits, two registered read ports, one write port.
// Valid bits give the reset contents without a clearing pass. Uses rsie_pkg.
module rsie_regfile
   import rsie_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         rd_en,
   input  logic [4:0]   rd_addr_a,
   input  logic [4:0]   rd_addr_b,
   input  rf_write_type wr,
   output logic [31:0]  rd_data_a,
   output logic [31:0]  rd_data_b
);

   logic [31:0] regs_mem [32];
   logic [31:0] valid_ff;
   logic [31:0] rd_a_ff;
   logic [31:0] rd_b_ff;
   logic [31:0] rd_a_in;
   logic [31:0] rd_b_in;

   function automatic logic [31:0] reset_value(input logic [4:0] idx);
      return (idx == REG_SP) ? STACK_TOP : 32'd0;
   endfunction

   // write-through: a read at the address being written returns the new value
   always_comb begin
      if (wr.en && (wr.addr == rd_addr_a)) begin
         rd_a_in = wr.data;
      end else if (valid_ff[rd_addr_a]) begin
         rd_a_in = regs_mem[rd_addr_a];
      end else begin
         rd_a_in = reset_value(rd_addr_a);
      end
      if (wr.en && (wr.addr == rd_addr_b)) begin
         rd_b_in = wr.data;
      end else if (valid_ff[rd_addr_b]) begin
         rd_b_in = regs_mem[rd_addr_b];
      end else begin
         rd_b_in = reset_value(rd_addr_b);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff <= rd_a_in;
         rd_b_ff <= rd_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/core/rsie_dmem.sv
// Data memory: DATA_WORDS x 32 bits, byte-lane writes, one registered read.
// Clears itself word by word after reset and flags busy meanwhile. Uses rsie_pkg.
module rsie_dmem
   import rsie_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dmem_write_type     wr,
   input  logic               rd_en,
   input  logic [DMEM_AW-1:0] rd_addr,
   output logic [31:0]        rd_data,
   output logic               busy
);

   logic [3:0][7:0]    data_mem [DATA_WORDS];
   logic [DMEM_AW-1:0] clr_addr_ff;
   logic               busy_ff;
   logic [31:0]        rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + DMEM_AW'(1);
         if (clr_addr_ff == '1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         data_mem[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         for (int lane = 0; lane < 4; lane++) begin
            if (wr.be[lane]) begin
               data_mem[wr.addr][lane] <= wr.data[lane*8 +: 8];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= data_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

FILE: rtl/core/risc_subset_instruction_executor.sv
// Path: an accepted transaction passes the register read, execute and result stages
// in that order, and waits in them only while rsp_stall holds the pipe.
// Throughput: one per cycle if req_stall is low; rsp_stall on a held result freezes all three stages.
// Reset: the PC goes to START_PC and the register file to its reset values at once;
// the data memory is then cleared word by word, all DATA_WORDS (4096) words, with
// req_stall high throughout. Uses rsie_pkg, rsie_regfile and rsie_dmem.
module risc_subset_instruction_executor
   import rsie_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   typedef enum logic [1:0] {
      LOAD_NONE,
      LOAD_BYTE,
      LOAD_UBYTE,
      LOAD_WORD
   } load_kind_type;

   // ---------------------------------------------------------------------------
   // Pipeline control: every stage advances together whenever the result stage
   // is empty or its transaction is being taken.
   // ---------------------------------------------------------------------------
   logic advance;
   logic req_accept;
   logic dmem_busy;
   logic s3_valid_ff;

   assign advance    = !s3_valid_ff || !rsp_stall;
   assign req_stall  = dmem_busy || !advance;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------------
   // Register read addresses. SYSCALL reads registers 2 and 4 through the
   // normal ports so that forwarding covers them as well.
   // ---------------------------------------------------------------------------
   logic        req_is_syscall;
   logic [4:0]  rf_addr_a;
   logic [4:0]  rf_addr_b;
   logic [31:0] rf_data_a;
   logic [31:0] rf_data_b;
   rf_write_type rf_wr;

   assign req_is_syscall = (req_payload.instr_word[31:26] == OP_SPECIAL) &&
                           (req_payload.instr_word[5:0] == FN_SYSCALL);
   assign rf_addr_a = req_is_syscall ? REG_V0 : req_payload.instr_word[25:21];
   assign rf_addr_b = req_is_syscall ? REG_A0 : req_payload.instr_word[20:16];

   rsie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (advance),
      .rd_addr_a (rf_addr_a),
      .rd_addr_b (rf_addr_b),
      .wr        (rf_wr),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b)
   );

   // ---------------------------------------------------------------------------
   // Stage 1: accepted transaction, register operands arrive from the file.
   // ---------------------------------------------------------------------------
   logic            s1_valid_ff;
   req_payload_type s1_req_ff;
   logic [4:0]      s1_rs_ff;
   logic [4:0]      s1_rt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_req_ff <= req_payload;
         s1_rs_ff  <= rf_addr_a;
         s1_rt_ff  <= rf_addr_b;
      end
   end

   // ---------------------------------------------------------------------------
   // Result stage signals, needed early for forwarding.
   // ---------------------------------------------------------------------------
   rsp_payload_type s3_rsp_ff;
   load_kind_type   s3_load_ff;
   logic [1:0]      s3_off_ff;
   logic [31:0]     dmem_rdata;
   logic [7:0]      s3_byte;
   logic [31:0]     s3_value;
   logic            s3_wb;

   assign s3_byte = dmem_rdata[{s3_off_ff, 3'b000} +: 8];

   always_comb begin
      case (s3_load_ff)
         LOAD_BYTE:  s3_value = {{24{s3_byte[7]}}, s3_byte};
         LOAD_UBYTE: s3_value = {24'd0, s3_byte};
         LOAD_WORD:  s3_value = dmem_rdata;
         default:    s3_value = s3_rsp_ff.dest_value;
      endcase
   end

   // the result stage writes back as its transaction leaves
   assign s3_wb = s3_valid_ff && s3_rsp_ff.reg_written;

   assign rf_wr.en   = s3_wb && !rsp_stall;
   assign rf_wr.addr = s3_rsp_ff.dest_index;
   assign rf_wr.data = s3_value;

   // ---------------------------------------------------------------------------
   // Stage 2: execute. Operands taken from stage 1 merge the write that leaves
   // the result stage on the same edge; in stage 2 they merge the result stage.
   // ---------------------------------------------------------------------------
   logic            s2_valid_ff;
   req_payload_type s2_req_ff;
   logic [4:0]      s2_rs_ff;
   logic [4:0]      s2_rt_ff;
   logic [31:0]     s2_a_ff;
   logic [31:0]     s2_b_ff;
   logic [31:0]     s2_a_in;
   logic [31:0]     s2_b_in;

   assign s2_a_in = (s3_wb && (s3_rsp_ff.dest_index == s1_rs_ff)) ? s3_value : rf_data_a;
   assign s2_b_in = (s3_wb && (s3_rsp_ff.dest_index == s1_rt_ff)) ? s3_value : rf_data_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_req_ff <= s1_req_ff;
         s2_rs_ff  <= s1_rs_ff;
         s2_rt_ff  <= s1_rt_ff;
         s2_a_ff   <= s2_a_in;
         s2_b_ff   <= s2_b_in;
      end
   end

   logic [31:0]        pc_ff;
   logic [31:0]        ex_a;
   logic [31:0]        ex_b;
   logic [31:0]        ex_iw;
   logic [5:0]         ex_op;
   logic [5:0]         ex_fn;
   logic [4:0]         ex_rt;
   logic [4:0]         ex_rd;
   logic [4:0]         ex_sh;
   logic [31:0]        ex_simm;
   logic [31:0]        ex_zimm;
   logic [31:0]        ex_pc4;
   logic [31:0]        ex_sum;
   logic [31:0]        ex_ea;
   logic [31:0]        ex_jtarget;
   logic [31:0]        ex_btarget;
   logic               ex_ovf;
   rsp_payload_type    ex_rsp;
   load_kind_type      ex_load;
   logic               ex_mem_we;
   logic [3:0]         ex_mem_be;
   logic [31:0]        ex_mem_data;
   logic [DMEM_AW-1:0] ex_mem_addr;
   logic [DMEM_AW-1:0] ex_rd_addr;
   dmem_write_type     dmem_wr;

   assign ex_a = (s3_wb && (s3_rsp_ff.dest_index == s2_rs_ff)) ? s3_value : s2_a_ff;
   assign ex_b = (s3_wb && (s3_rsp_ff.dest_index == s2_rt_ff)) ? s3_value : s2_b_ff;

   assign ex_iw      = s2_req_ff.instr_word;
   assign ex_op      = ex_iw[31:26];
   assign ex_fn      = ex_iw[5:0];
   assign ex_rt      = ex_iw[20:16];
   assign ex_rd      = ex_iw[15:11];
   assign ex_sh      = ex_iw[10:6];
   assign ex_simm    = {{16{ex_iw[15]}}, ex_iw[15:0]};
   assign ex_zimm    = {16'd0, ex_iw[15:0]};
   assign ex_pc4     = pc_ff + 32'd4;
   assign ex_sum     = ex_a + ex_b;
   assign ex_ea      = ex_a + ex_simm;
   assign ex_jtarget = (ex_pc4 & JUMP_REGION_MASK) | {4'd0, ex_iw[25:0], 2'b00};
   assign ex_btarget = ex_pc4 + {ex_simm[29:0], 2'b00};
   assign ex_ovf     = (ex_a[31] == ex_b[31]) && (ex_sum[31] != ex_a[31]);
   assign ex_rd_addr = ex_ea[DMEM_AW+1:2];

   always_comb begin
      ex_rsp.next_pc      = ex_pc4;
      ex_rsp.trap         = TRAP_NONE;
      ex_rsp.syscall_code = '0;
      ex_rsp.syscall_arg  = '0;
      ex_rsp.reg_written  = 1'b0;
      ex_rsp.dest_index   = '0;
      ex_rsp.dest_value   = '0;
      ex_load             = LOAD_NONE;
      ex_mem_we           = 1'b0;
      ex_mem_be           = 4'hf;
      ex_mem_data         = ex_b;
      ex_mem_addr         = ex_rd_addr;

      if (s2_req_ff.operation) begin
         // preload: write the word, hold the PC
         ex_rsp.next_pc = pc_ff;
         ex_mem_we      = 1'b1;
         ex_mem_addr    = DMEM_AW'(s2_req_ff.preload_addr);
         ex_mem_data    = s2_req_ff.preload_data;
      end else if (ex_op == OP_SPECIAL) begin
         ex_rsp.dest_index  = ex_rd;
         ex_rsp.reg_written = 1'b1;
         unique case (ex_fn)
            FN_SYSCALL: begin
               ex_rsp.reg_written  = 1'b0;
               ex_rsp.trap         = TRAP_SYSCALL;
               ex_rsp.syscall_code = ex_a;
               ex_rsp.syscall_arg  = ex_b;
            end
            FN_AND:  ex_rsp.dest_value = ex_a & ex_b;
            FN_OR:   ex_rsp.dest_value = ex_a | ex_b;
            FN_XOR:  ex_rsp.dest_value = ex_a ^ ex_b;
            FN_SLL:  ex_rsp.dest_value = ex_b << ex_sh;
            FN_SRL:  ex_rsp.dest_value = ex_b >> ex_sh;
            FN_SRA:  ex_rsp.dest_value = 32'($signed(ex_b) >>> ex_sh);
            FN_JR: begin
               ex_rsp.reg_written = 1'b0;
               ex_rsp.next_pc     = ex_a;
            end
            FN_JALR: begin
               ex_rsp.dest_index = REG_RA;
               ex_rsp.dest_value = ex_pc4;
               ex_rsp.next_pc    = ex_a;
            end
            FN_ADD: begin
               ex_rsp.dest_value = ex_sum;
               if (ex_ovf) begin
                  ex_rsp.reg_written = 1'b0;
                  ex_rsp.trap        = TRAP_OVERFLOW;
                  ex_rsp.next_pc     = pc_ff;
               end
            end
            FN_ADDU: ex_rsp.dest_value = ex_sum;
            FN_SLT:  ex_rsp.dest_value = {31'd0, $signed(ex_a) < $signed(ex_b)};
            default: begin
               ex_rsp.reg_written = 1'b0;
               ex_rsp.trap        = TRAP_ILLEGAL;
               ex_rsp.next_pc     = pc_ff;
            end
         endcase
      end else begin
         ex_rsp.dest_index  = ex_rt;
         ex_rsp.reg_written = 1'b1;
         unique case (ex_op)
            OP_J: begin
               ex_rsp.reg_written = 1'b0;
               ex_rsp.next_pc     = ex_jtarget;
            end
            OP_JAL: begin
               ex_rsp.dest_index = REG_RA;
               ex_rsp.dest_value = ex_pc4;
               ex_rsp.next_pc    = ex_jtarget;
            end
            OP_BEQ: begin
               ex_rsp.reg_written = 1'b0;
               if (ex_a == ex_b) begin
                  ex_rsp.next_pc = ex_btarget;
               end
            end
            OP_BNE: begin
               ex_rsp.reg_written = 1'b0;
               if (ex_a != ex_b) begin
                  ex_rsp.next_pc = ex_btarget;
               end
            end
            OP_ADDIU: ex_rsp.dest_value = ex_ea;
            OP_ORI:   ex_rsp.dest_value = ex_a | ex_zimm;
            OP_XORI:  ex_rsp.dest_value = ex_a ^ ex_zimm;
            OP_LUI:   ex_rsp.dest_value = {ex_iw[15:0], 16'd0};
            OP_LB:    ex_load = LOAD_BYTE;
            OP_LBU:   ex_load = LOAD_UBYTE;
            OP_LW:    ex_load = LOAD_WORD;
            OP_SB: begin
               ex_rsp.reg_written = 1'b0;
               ex_mem_we          = 1'b1;
               ex_mem_be          = 4'b0001 << ex_ea[1:0];
               ex_mem_data        = {4{ex_b[7:0]}};
            end
            OP_SW: begin
               ex_rsp.reg_written = 1'b0;
               ex_mem_we          = 1'b1;
            end
            default: begin
               ex_rsp.reg_written = 1'b0;
               ex_rsp.trap        = TRAP_ILLEGAL;
               ex_rsp.next_pc     = pc_ff;
            end
         endcase
      end

      // drop writes to register 0 and report them as no write at all
      if (!ex_rsp.reg_written || (ex_rsp.dest_index == '0)) begin
         ex_rsp.reg_written = 1'b0;
         ex_rsp.dest_index  = '0;
         ex_rsp.dest_value  = '0;
         ex_load            = LOAD_NONE;
      end
   end

   // stores and preloads write as their transaction leaves stage 2; loads read
   // on the same edge, so memory order follows transaction order
   assign dmem_wr.en   = s2_valid_ff && advance && ex_mem_we;
   assign dmem_wr.addr = ex_mem_addr;
   assign dmem_wr.be   = ex_mem_be;
   assign dmem_wr.data = ex_mem_data;

   rsie_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .wr      (dmem_wr),
      .rd_en   (advance),
      .rd_addr (ex_rd_addr),
      .rd_data (dmem_rdata),
      .busy    (dmem_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= START_PC;
      end else if (advance && s2_valid_ff) begin
         pc_ff <= ex_rsp.next_pc;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: result register. Load data is aligned and extended here.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_rsp_ff  <= ex_rsp;
         s3_load_ff <= ex_load;
         s3_off_ff  <= ex_ea[1:0];
      end
   end

   assign rsp_valid = s3_valid_ff;

   always_comb begin
      rsp_payload            = s3_rsp_ff;
      rsp_payload.dest_value = s3_value;
   end

endmodule

FILE: rtl/core/rsie_checker.sv
// Port-level checker for the RISC subset instruction executor, with its bind.
// Watches the request and result transactions over time. Uses rsie_pkg.
module rsie_checker
   import rsie_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_payload,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   logic req_acc;

   assign req_acc = req_valid && !req_stall;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // the memory clearing pass blocks requests straight after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request taken before memory clear");

   // an accepted transaction reaches the result port while rsp_stall stays low behind it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing three cycles after acceptance");

   // with no new requests and no back-pressure the pipe drains
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!req_acc && !rsp_stall) ##1 (!req_acc && !rsp_stall) ##1 (!req_acc && !rsp_stall)
      |=> !rsp_valid)
      else $error("result appeared without a request");

   // a trapping transaction writes no register
   a_trap_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.trap != TRAP_NONE) |-> !rsp_payload.reg_written)
      else $error("register written on a trap");

endmodule

bind risc_subset_instruction_executor rsie_checker u_rsie_checker (.*);
